### rtl/core/smpg_pkg.sv
package smpg_pkg;

   localparam int SMPG_COS_DEPTH     = 256;
   localparam int SMPG_FRACTION_BITS = 16;

   localparam int ANGLE_W     = 12;
   localparam int TIME_W      = 16;
   localparam int PULSE_W     = 12;
   localparam int SPEED_W     = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // speed numerator after dropping the fraction bits
   localparam int SPEED_NUM_W = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROFILE_MODE = 2'd0,
      CSR_SWEEP_TIME   = 2'd1,
      CSR_MIN_PULSE    = 2'd2,
      CSR_MAX_PULSE    = 2'd3
   } csr_index_type;

   // profile_mode register values
   localparam logic PROFILE_TRAPEZOID = 1'b0;
   localparam logic PROFILE_SCURVE    = 1'b1;

   localparam logic                MODE_RESET  = 1'b1;
   localparam logic [TIME_W-1:0]  SWEEP_RESET = 16'd2000;
   localparam logic [PULSE_W-1:0] MIN_RESET   = 12'd500;
   localparam logic [PULSE_W-1:0] MAX_RESET   = 12'd2500;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;

   localparam logic [63:0] TAYLOR_DIV [12] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
      64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
   };

   typedef struct packed {
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] target_angle;
      logic               sweep_done;
   } prof_pay_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_width_us;
      logic [ANGLE_W-1:0] angle_now;
      logic               sweep_done;
      logic               speed_sat;
   } scale_pay_type;

   // sin(x) in Q30 by integer Taylor series; only used for table constants
   function automatic logic [30:0] sine_q30(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [65:0] acc;
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed({2'b00, x});
      for (int k = 0; k < 12; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (k[0] == 1'b0) acc = acc - $signed({2'b00, term});
         else              acc = acc + $signed({2'b00, term});
      end
      if (acc < 0) return 31'd0;
      if (acc > $signed({2'b00, Q30_ONE})) return Q30_ONE[30:0];
      return acc[30:0];
   endfunction

endpackage

### rtl/core/servo_motion_profile_generator.sv
// Servo motion profile generator.
// Request word: elapsed time of a sweep plus its start and target angles
// (1/16 degree). Response word: servo pulse width, commanded angle, speed in
// 1/16 degree per second (saturating) and a sweep-done flag.
// Both channels use valid/stall; a word moves when valid is high and stall is
// low. The csr port writes profile mode, sweep time and the pulse limits; write
// it only while no request is in flight.
// A restoring divider with one stage per fraction bit forms the time fraction,
// six stages evaluate the profile, five scale to angle and pulse, and a 16-stage
// divider forms the speed. One word is accepted every cycle while the response is
// not stalled.
// Reset clears every stage valid and loads the default configuration
// (S-curve, 2000 ms, 500..2500 us).
// A stalled response freezes the whole pipeline in place and raises req_stall
// in the same cycle; nothing is dropped or repeated.
module servo_motion_profile_generator import smpg_pkg::*; #(
   parameter int COS_TABLE_DEPTH = SMPG_COS_DEPTH,
   parameter int FRACTION_BITS   = SMPG_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TIME_W-1:0]      req_elapsed_ms,
   input  logic [ANGLE_W-1:0]     req_start_angle,
   input  logic [ANGLE_W-1:0]     req_target_angle,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PULSE_W-1:0]     rsp_pulse_width_us,
   output logic [ANGLE_W-1:0]     rsp_angle_now,
   output logic [SPEED_W-1:0]     rsp_speed_now,
   output logic                   rsp_sweep_done,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int FB = FRACTION_BITS;

   logic               mode_ff;
   logic [TIME_W-1:0]  sweep_ff;
   logic [PULSE_W-1:0] min_ff, max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         sweep_ff <= SWEEP_RESET;
         min_ff   <= MIN_RESET;
         max_ff   <= MAX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROFILE_MODE: mode_ff  <= csr_data[0];
            CSR_SWEEP_TIME:   sweep_ff <= csr_data;
            CSR_MIN_PULSE:    min_ff   <= csr_data[PULSE_W-1:0];
            CSR_MAX_PULSE:    max_ff   <= csr_data[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   logic              en;
   logic [TIME_W-1:0] sweep_eff;
   logic              done_in;
   prof_pay_type      req_pay;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign sweep_eff = (sweep_ff == '0) ? TIME_W'(1) : sweep_ff;
   assign done_in   = req_elapsed_ms >= sweep_eff;

   always_comb begin
      req_pay.start_angle  = req_start_angle;
      req_pay.target_angle = req_target_angle;
      req_pay.sweep_done   = done_in;
   end

   // time fraction p = elapsed / T, FB quotient bits
   logic          frac_valid;
   logic [FB-1:0] frac_quot;
   prof_pay_type  frac_pay;
   logic [FB:0]   frac_p;

   smpg_divider #(
      .DEN_W  (TIME_W),
      .Q_BITS (FB),
      .PAY_W  ($bits(prof_pay_type))
   ) u_frac_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && en),
      .in_rem    (done_in ? '0 : req_elapsed_ms),
      .in_low    ('0),
      .den       (sweep_eff),
      .in_pay    (req_pay),
      .out_valid (frac_valid),
      .out_quot  (frac_quot),
      .out_pay   (frac_pay)
   );

   assign frac_p = frac_pay.sweep_done ? {1'b1, {FB{1'b0}}} : {1'b0, frac_quot};

   logic         prof_valid;
   logic [FB:0]  prof_pos, prof_spd;
   prof_pay_type prof_pay;

   smpg_profile #(
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_profile (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .profile_mode (mode_ff),
      .in_valid     (frac_valid),
      .in_p         (frac_p),
      .in_pay       (frac_pay),
      .out_valid    (prof_valid),
      .out_pos      (prof_pos),
      .out_spd      (prof_spd),
      .out_pay      (prof_pay)
   );

   logic                   scl_valid;
   scale_pay_type          scl_pay;
   logic [SPEED_NUM_W-1:0] scl_num;

   smpg_scale #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (prof_valid),
      .in_pos     (prof_pos),
      .in_spd     (prof_spd),
      .in_pay     (prof_pay),
      .sweep_time (sweep_eff),
      .min_pulse  (min_ff),
      .max_pulse  (max_ff),
      .out_valid  (scl_valid),
      .out_pay    (scl_pay),
      .out_num    (scl_num)
   );

   // speed = num / T; overflow already flagged, so the top byte is below T
   logic               spd_valid;
   logic [SPEED_W-1:0] spd_quot;
   scale_pay_type      spd_pay;

   smpg_divider #(
      .DEN_W  (TIME_W),
      .Q_BITS (SPEED_W),
      .PAY_W  ($bits(scale_pay_type))
   ) u_speed_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (scl_valid),
      .in_rem    (scl_pay.speed_sat ? '0 : TIME_W'(scl_num[SPEED_NUM_W-1:SPEED_W])),
      .in_low    (scl_num[SPEED_W-1:0]),
      .den       (sweep_eff),
      .in_pay    (scl_pay),
      .out_valid (spd_valid),
      .out_quot  (spd_quot),
      .out_pay   (spd_pay)
   );

   assign rsp_valid          = spd_valid;
   assign rsp_pulse_width_us = spd_pay.pulse_width_us;
   assign rsp_angle_now      = spd_pay.angle_now;
   assign rsp_sweep_done     = spd_pay.sweep_done;
   assign rsp_speed_now      = spd_pay.sweep_done ? '0 :
                               spd_pay.speed_sat  ? '1 : spd_quot;

   logic [PULSE_W-1:0] lo_pulse, hi_pulse;
   assign lo_pulse = (max_ff < min_ff) ? max_ff : min_ff;
   assign hi_pulse = (max_ff < min_ff) ? min_ff : max_ff;

   a_done_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sweep_done |-> rsp_speed_now == '0)
      else $error("finished sweep reports nonzero speed");

   a_pulse_limits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pulse_width_us >= lo_pulse && rsp_pulse_width_us <= hi_pulse)
      else $error("pulse width outside configured limits");

endmodule

### rtl/core/smpg_divider.sv
module smpg_divider #(
   parameter int DEN_W  = 16,
   parameter int Q_BITS = 16,
   parameter int PAY_W  = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [Q_BITS-1:0] in_low,
   input  logic [DEN_W-1:0]  den,
   input  logic [PAY_W-1:0]  in_pay,
   output logic              out_valid,
   output logic [Q_BITS-1:0] out_quot,
   output logic [PAY_W-1:0]  out_pay
);

   // one restoring step per stage, quotient MSB first
   logic [Q_BITS-1:0] valid_ff;
   logic [Q_BITS-1:0] valid_in;
   logic [DEN_W-1:0]  rem_ff   [Q_BITS];
   logic [DEN_W-1:0]  rem_src  [Q_BITS];
   logic [DEN_W-1:0]  rem_in   [Q_BITS];
   logic [Q_BITS-1:0] low_ff   [Q_BITS];
   logic [Q_BITS-1:0] low_src  [Q_BITS];
   logic [Q_BITS-1:0] quot_ff  [Q_BITS];
   logic [Q_BITS-1:0] quot_src [Q_BITS];
   logic [Q_BITS-1:0] quot_in  [Q_BITS];
   logic [PAY_W-1:0]  pay_ff   [Q_BITS];
   logic [PAY_W-1:0]  pay_src  [Q_BITS];
   logic [DEN_W:0]    shifted  [Q_BITS];
   logic [Q_BITS-1:0] fits;

   always_comb begin
      valid_in[0] = in_valid;
      rem_src[0]  = in_rem;
      low_src[0]  = in_low;
      quot_src[0] = '0;
      pay_src[0]  = in_pay;
      for (int k = 1; k < Q_BITS; k++) begin
         valid_in[k] = valid_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         low_src[k]  = low_ff[k-1];
         quot_src[k] = quot_ff[k-1];
         pay_src[k]  = pay_ff[k-1];
      end
      for (int k = 0; k < Q_BITS; k++) begin
         shifted[k] = {rem_src[k], low_src[k][Q_BITS-1]};
         fits[k]    = shifted[k] >= {1'b0, den};
         rem_in[k]  = fits[k] ? DEN_W'(shifted[k] - {1'b0, den}) : shifted[k][DEN_W-1:0];
         quot_in[k] = Q_BITS'({quot_src[k], fits[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Q_BITS; k++) begin
            rem_ff[k]  <= rem_in[k];
            low_ff[k]  <= low_src[k] << 1;
            quot_ff[k] <= quot_in[k];
            pay_ff[k]  <= pay_src[k];
         end
      end
   end

   assign out_valid = valid_ff[Q_BITS-1];
   assign out_quot  = quot_ff[Q_BITS-1];
   assign out_pay   = pay_ff[Q_BITS-1];

endmodule

### rtl/core/smpg_profile.sv
module smpg_profile import smpg_pkg::*; #(
   parameter int COS_TABLE_DEPTH = SMPG_COS_DEPTH,
   parameter int FRACTION_BITS   = SMPG_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   profile_mode,
   input  logic                   in_valid,
   input  logic [FRACTION_BITS:0] in_p,
   input  prof_pay_type           in_pay,
   output logic                   out_valid,
   output logic [FRACTION_BITS:0] out_pos,
   output logic [FRACTION_BITS:0] out_spd,
   output prof_pay_type           out_pay
);

   localparam int FB  = FRACTION_BITS;
   localparam int PW  = FB + 1;
   localparam int RW  = FB + $clog2(COS_TABLE_DEPTH) + 2;
   localparam int AW  = RW - 1;
   localparam int IW  = $clog2(COS_TABLE_DEPTH + 1);
   localparam int PRW = 31 + PW;

   localparam logic [PW-1:0] ONE        = {1'b1, {FB{1'b0}}};
   localparam logic [PW-1:0] SPD_CRUISE = PW'((3 * (64'd1 << FB)) >> 1);
   localparam logic [RW-1:0] QUARTER    = RW'(COS_TABLE_DEPTH) << FB;
   localparam logic [RW-1:0] HALF_WAVE  = QUARTER << 1;

   typedef enum logic [2:0] {
      RG_ACCEL  = 3'b001,
      RG_CRUISE = 3'b010,
      RG_DECEL  = 3'b100
   } region_type;

   // quarter-wave sine, Q30
   logic [30:0] sine_tab [COS_TABLE_DEPTH + 1];

   for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_tab
      localparam logic [63:0] X = (HALF_PI_Q30 * 64'(g) + 64'(COS_TABLE_DEPTH / 2))
                                  / 64'(COS_TABLE_DEPTH);
      localparam logic [30:0] V = (g == 0) ? 31'd0 :
                                  (g == COS_TABLE_DEPTH) ? Q30_ONE[30:0] : sine_q30(X);
      assign sine_tab[g] = V;
   end

   logic [5:0]   valid_ff;
   prof_pay_type pay_ff [6];

   // stage 0: phase and lookup arguments, trapezoid region
   logic [RW-1:0]   r;
   logic [AW-1:0]   a_c, a_s;
   logic            cos_low;
   logic [PW+1:0]   p3;
   region_type      region;
   logic [PW-1:0]   m;

   always_comb begin
      r       = RW'(in_p) * RW'(2 * COS_TABLE_DEPTH);
      cos_low = r <= QUARTER;
      a_c     = cos_low ? AW'(QUARTER - r) : AW'(r - QUARTER);
      a_s     = (r > QUARTER) ? AW'(HALF_WAVE - r) : AW'(r);
      p3      = (PW+2)'(in_p) * (PW+2)'(3);
      if (p3 < (PW+2)'(ONE))              region = RG_ACCEL;
      else if (p3 < ((PW+2)'(ONE) << 1))  region = RG_CRUISE;
      else                                region = RG_DECEL;
      m = (region == RG_ACCEL) ? in_p : ONE - in_p;
   end

   logic [AW-1:0] a_c_s0_ff, a_s_s0_ff;
   logic          cos_low_s0_ff;
   region_type    region_s0_ff;
   logic [PW-1:0] m_s0_ff, p_s0_ff;

   // stage 1: table reads, m squared
   logic [AW-FB-1:0] ic_full, is_full;
   logic [IW-1:0]    ic, ic_nxt, is, is_nxt;
   logic [PW+2:0]    mid_full;
   logic [PW+3:0]    sp9;
   logic [PW-1:0]    spd_tr;

   always_comb begin
      ic_full = a_c_s0_ff[AW-1:FB];
      is_full = a_s_s0_ff[AW-1:FB];
      ic      = ic_full[IW-1:0];
      is      = is_full[IW-1:0];
      ic_nxt  = (ic == IW'(COS_TABLE_DEPTH)) ? ic : IW'(ic + 1'b1);
      is_nxt  = (is == IW'(COS_TABLE_DEPTH)) ? is : IW'(is + 1'b1);
      mid_full = (PW+3)'(p_s0_ff) * (PW+3)'(6) - (PW+3)'(ONE) + (PW+3)'(2);
      sp9      = (PW+4)'(m_s0_ff) * (PW+4)'(9) + (PW+4)'(1);
      spd_tr   = (region_s0_ff == RG_CRUISE) ? SPD_CRUISE : PW'(sp9 >> 1);
   end

   logic [30:0]     lo_c_ff, hi_c_ff, lo_s_ff, hi_s_ff;
   logic [FB-1:0]   f_c_ff, f_s_ff;
   logic [2*PW-1:0] mm_s1_ff;
   region_type      region_s1_ff;
   logic            cos_low_s1_ff;
   logic [PW-1:0]   mid_s1_ff, spd_tr_s1_ff;

   // stage 2: interpolation products, trapezoid position
   logic [2*PW+3:0] v_full;
   logic [PW-1:0]   v, pos_tr;

   always_comb begin
      v_full = (2*PW+4)'(mm_s1_ff) * (2*PW+4)'(9) + ((2*PW+4)'(1) << (FB + 1));
      v      = PW'(v_full >> (FB + 2));
      case (region_s1_ff)
         RG_ACCEL:  pos_tr = v;
         RG_DECEL:  pos_tr = ONE - v;
         default:   pos_tr = mid_s1_ff;
      endcase
   end

   logic [PRW-1:0] pl_c_ff, ph_c_ff, pl_s_ff, ph_s_ff;
   logic           cos_low_s2_ff;
   logic [PW-1:0]  pos_tr_s2_ff, spd_tr_s2_ff;

   // stage 3: interpolated cosine and sine
   logic [PRW:0] c_sum, s_sum;

   always_comb begin
      c_sum = (PRW+1)'(pl_c_ff) + (PRW+1)'(ph_c_ff);
      s_sum = (PRW+1)'(pl_s_ff) + (PRW+1)'(ph_s_ff);
   end

   logic [30:0]   c_s3_ff, s_s3_ff;
   logic          cos_low_s3_ff;
   logic [PW-1:0] pos_tr_s3_ff, spd_tr_s3_ff;

   // stage 4: cosine position, sine times pi/2
   logic [31:0]   pos30, pos_full;
   logic [PW-1:0] pos_c;
   logic [61:0]   sprod;

   always_comb begin
      if (cos_low_s3_ff) pos30 = (32'(Q30_ONE) - 32'(c_s3_ff) + 32'd1) >> 1;
      else               pos30 = (32'(Q30_ONE) + 32'(c_s3_ff) + 32'd1) >> 1;
      pos_full = (pos30 + (32'd1 << (29 - FB))) >> (30 - FB);
      pos_c    = (pos_full > 32'(ONE)) ? ONE : PW'(pos_full);
      sprod    = 62'(s_s3_ff) * 62'(HALF_PI_Q30[30:0]);
   end

   logic [PW-1:0] pos_c_s4_ff, pos_tr_s4_ff, spd_tr_s4_ff;
   logic [61:0]   sprod_s4_ff;

   // stage 5: cosine speed, profile select
   logic [62:0]   spd_full;
   logic [PW-1:0] spd_c;

   always_comb begin
      spd_full = (63'(sprod_s4_ff) + (63'd1 << (59 - FB))) >> (60 - FB);
      spd_c    = PW'(spd_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff[0] <= in_pay;
         for (int k = 1; k < 6; k++) pay_ff[k] <= pay_ff[k-1];

         a_c_s0_ff     <= a_c;
         a_s_s0_ff     <= a_s;
         cos_low_s0_ff <= cos_low;
         region_s0_ff  <= region;
         m_s0_ff       <= m;
         p_s0_ff       <= in_p;

         lo_c_ff       <= sine_tab[ic];
         hi_c_ff       <= sine_tab[ic_nxt];
         f_c_ff        <= a_c_s0_ff[FB-1:0];
         lo_s_ff       <= sine_tab[is];
         hi_s_ff       <= sine_tab[is_nxt];
         f_s_ff        <= a_s_s0_ff[FB-1:0];
         mm_s1_ff      <= (2*PW)'(m_s0_ff) * (2*PW)'(m_s0_ff);
         region_s1_ff  <= region_s0_ff;
         cos_low_s1_ff <= cos_low_s0_ff;
         mid_s1_ff     <= PW'(mid_full >> 2);
         spd_tr_s1_ff  <= spd_tr;

         pl_c_ff       <= PRW'(lo_c_ff) * PRW'(ONE - PW'(f_c_ff));
         ph_c_ff       <= PRW'(hi_c_ff) * PRW'(f_c_ff);
         pl_s_ff       <= PRW'(lo_s_ff) * PRW'(ONE - PW'(f_s_ff));
         ph_s_ff       <= PRW'(hi_s_ff) * PRW'(f_s_ff);
         cos_low_s2_ff <= cos_low_s1_ff;
         pos_tr_s2_ff  <= pos_tr;
         spd_tr_s2_ff  <= spd_tr_s1_ff;

         c_s3_ff       <= 31'(c_sum >> FB);
         s_s3_ff       <= 31'(s_sum >> FB);
         cos_low_s3_ff <= cos_low_s2_ff;
         pos_tr_s3_ff  <= pos_tr_s2_ff;
         spd_tr_s3_ff  <= spd_tr_s2_ff;

         pos_c_s4_ff   <= pos_c;
         sprod_s4_ff   <= sprod;
         pos_tr_s4_ff  <= pos_tr_s3_ff;
         spd_tr_s4_ff  <= spd_tr_s3_ff;

         out_pos       <= profile_mode ? pos_c_s4_ff : pos_tr_s4_ff;
         out_spd       <= profile_mode ? spd_c : spd_tr_s4_ff;
      end
   end

   assign out_valid = valid_ff[5];
   assign out_pay   = pay_ff[5];

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_pos <= ONE)
      else $error("profile position above full scale");

endmodule

### rtl/core/smpg_scale.sv
module smpg_scale import smpg_pkg::*; #(
   parameter int FRACTION_BITS = SMPG_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [FRACTION_BITS:0] in_pos,
   input  logic [FRACTION_BITS:0] in_spd,
   input  prof_pay_type           in_pay,
   input  logic [TIME_W-1:0]      sweep_time,
   input  logic [PULSE_W-1:0]     min_pulse,
   input  logic [PULSE_W-1:0]     max_pulse,
   output logic                   out_valid,
   output scale_pay_type          out_pay,
   output logic [SPEED_NUM_W-1:0] out_num
);

   localparam int FB = FRACTION_BITS;
   localparam int PW = FB + 1;
   localparam int XW = 12 + PW;
   localparam int NW = FB + SPEED_NUM_W;

   // x / 2880 == (x * RECIP) >> 36 for x < 2^25
   localparam logic [24:0] RECIP     = 25'd23860930;
   localparam int          RECIP_SH  = 36;
   localparam logic [24:0] HALF_FULL = 25'd1440;

   logic [4:0] valid_ff;

   // stage 0: angle delta times position and speed
   logic               dir;
   logic [ANGLE_W-1:0] diff;

   always_comb begin
      dir  = in_pay.target_angle >= in_pay.start_angle;
      diff = dir ? in_pay.target_angle - in_pay.start_angle
                 : in_pay.start_angle - in_pay.target_angle;
   end

   logic [XW-1:0]      pp_s0_ff, ps_s0_ff;
   logic               dir_s0_ff, done_s0_ff;
   logic [ANGLE_W-1:0] start_s0_ff;

   // stage 1: rounded angle, speed numerator
   logic [XW-1:0]      off_full;
   logic [ANGLE_W-1:0] off_a, angle;
   logic [NW-1:0]      num;

   always_comb begin
      off_full = (pp_s0_ff + (XW'(1) << (FB - 1))) >> FB;
      off_a    = off_full[ANGLE_W-1:0];
      angle    = dir_s0_ff ? start_s0_ff + off_a : start_s0_ff - off_a;
      num      = NW'(ps_s0_ff) * NW'(1000) + (NW'(sweep_time) << (FB - 1));
   end

   logic [ANGLE_W-1:0]     angle_s1_ff;
   logic [SPEED_NUM_W-1:0] num_s1_ff;
   logic                   done_s1_ff;

   // pulse limits
   logic               swapped;
   logic [PULSE_W-1:0] lo, hi, span;

   always_comb begin
      swapped = max_pulse < min_pulse;
      lo      = swapped ? max_pulse : min_pulse;
      hi      = swapped ? min_pulse : max_pulse;
      span    = hi - lo;
   end

   logic [23:0]            pprod_s2_ff;
   logic [ANGLE_W-1:0]     angle_s2_ff;
   logic [SPEED_NUM_W-1:0] num_s2_ff;
   logic                   done_s2_ff, sat_s2_ff;

   logic [49:0]            qm_s3_ff;
   logic [ANGLE_W-1:0]     angle_s3_ff;
   logic [SPEED_NUM_W-1:0] num_s3_ff;
   logic                   done_s3_ff, sat_s3_ff;

   // stage 4: pulse offset and clamp
   logic [13:0]        off_p, sum_p;
   logic [PULSE_W-1:0] pulse;

   always_comb begin
      off_p = qm_s3_ff[RECIP_SH +: 14];
      sum_p = 14'(min_pulse) + off_p;
      if (!swapped) pulse = (sum_p > 14'(hi)) ? hi : sum_p[PULSE_W-1:0];
      else          pulse = (off_p >= 14'(span)) ? lo : min_pulse - off_p[PULSE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_s0_ff    <= XW'(diff) * XW'(in_pos);
         ps_s0_ff    <= XW'(diff) * XW'(in_spd);
         dir_s0_ff   <= dir;
         done_s0_ff  <= in_pay.sweep_done;
         start_s0_ff <= in_pay.start_angle;

         angle_s1_ff <= angle;
         num_s1_ff   <= num[NW-1:FB];
         done_s1_ff  <= done_s0_ff;

         pprod_s2_ff <= 24'(span) * 24'(angle_s1_ff);
         angle_s2_ff <= angle_s1_ff;
         num_s2_ff   <= num_s1_ff;
         done_s2_ff  <= done_s1_ff;
         sat_s2_ff   <= TIME_W'(num_s1_ff[SPEED_NUM_W-1:SPEED_W]) >= sweep_time;

         qm_s3_ff    <= 50'(25'(pprod_s2_ff) + HALF_FULL) * 50'(RECIP);
         angle_s3_ff <= angle_s2_ff;
         num_s3_ff   <= num_s2_ff;
         done_s3_ff  <= done_s2_ff;
         sat_s3_ff   <= sat_s2_ff;

         out_pay.pulse_width_us <= pulse;
         out_pay.angle_now      <= angle_s3_ff;
         out_pay.sweep_done     <= done_s3_ff;
         out_pay.speed_sat      <= sat_s3_ff;
         out_num                <= num_s3_ff;
      end
   end

   assign out_valid = valid_ff[4];

endmodule

### test/servo_motion_profile_checker.sv
module servo_motion_profile_checker import smpg_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [TIME_W-1:0]      req_elapsed_ms,
   input  logic [ANGLE_W-1:0]     req_start_angle,
   input  logic [ANGLE_W-1:0]     req_target_angle,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [PULSE_W-1:0]     rsp_pulse_width_us,
   input  logic [ANGLE_W-1:0]     rsp_angle_now,
   input  logic [SPEED_W-1:0]     rsp_speed_now,
   input  logic                   rsp_sweep_done,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     errors,
   output int                     pending,
   output int                     checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          DEPTH   = SMPG_COS_DEPTH;
   localparam int          FB      = SMPG_FRACTION_BITS;
   localparam logic [63:0] ONE     = 64'd1 << FB;
   localparam logic [63:0] QUARTER = 64'(DEPTH) << FB;

   typedef struct {
      logic [PULSE_W-1:0] pulse;
      logic [ANGLE_W-1:0] angle;
      logic [SPEED_W-1:0] speed;
      logic               done;
   } motion_word_type;

   logic [63:0]        sine_q30_tab [DEPTH+1];
   logic               mode;
   logic [TIME_W-1:0]  sweep_ms;
   logic [PULSE_W-1:0] min_us, max_us;
   motion_word_type    motion_q [$];

   initial begin
      logic [63:0]        x, x2, term;
      logic signed [63:0] sum;
      for (int i = 0; i <= DEPTH; i++) begin
         x    = (HALF_PI_Q30 * i + DEPTH / 2) / DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (int k = 1; k <= 12; k++) begin
            term = ((term * x2) >> 30) / (64'(2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - $signed(term);
            else            sum = sum + $signed(term);
         end
         if (sum < 0) sum = 0;
         if (sum > $signed(Q30_ONE)) sum = $signed(Q30_ONE);
         sine_q30_tab[i] = sum;
      end
      sine_q30_tab[0]     = 0;
      sine_q30_tab[DEPTH] = Q30_ONE;
   end

   // sin(pi/2 * r / (DEPTH * ONE)) in Q30, r over the half wave
   function automatic logic [63:0] half_wave_sine(input logic [63:0] r_in);
      logic [63:0] r, i, f;
      r = r_in;
      if (r > QUARTER) r = (r > 2 * QUARTER) ? 64'd0 : 2 * QUARTER - r;
      i = r >> FB;
      f = r & (ONE - 1);
      if (i >= DEPTH) return sine_q30_tab[DEPTH];
      return (sine_q30_tab[i] * (ONE - f) + sine_q30_tab[i+1] * f) >> FB;
   endfunction

   function automatic motion_word_type predict_motion(input logic [TIME_W-1:0] el,
         input logic [ANGLE_W-1:0] st, input logic [ANGLE_W-1:0] tg);
      motion_word_type w;
      logic [63:0]  t, p, q, pos, spd, r, c, s, pos30, diff, off, angle;
      logic [63:0]  lo, hi, span, pulse, den, spd_out;
      logic         done;
      t    = (sweep_ms == 0) ? 64'd1 : 64'(sweep_ms);
      p    = (64'(el) * ONE) / t;
      if (p > ONE) p = ONE;
      done = (p == ONE);
      if (mode == PROFILE_TRAPEZOID) begin
         q = ONE - p;
         if (3 * p < ONE) begin
            pos = (9 * p * p + (64'd1 << (FB + 1))) >> (FB + 2);
            spd = (9 * p + 1) >> 1;
         end else if (3 * p < 2 * ONE) begin
            pos = (6 * p - ONE + 2) >> 2;
            spd = (3 * ONE) >> 1;
         end else begin
            pos = ONE - ((9 * q * q + (64'd1 << (FB + 1))) >> (FB + 2));
            spd = (9 * q + 1) >> 1;
         end
      end else begin
         r = p * 2 * DEPTH;
         if (r <= QUARTER) begin
            c     = half_wave_sine(QUARTER - r);
            pos30 = (Q30_ONE - c + 1) >> 1;
         end else begin
            c     = half_wave_sine(r - QUARTER);
            pos30 = (Q30_ONE + c + 1) >> 1;
         end
         pos = (pos30 + (64'd1 << (29 - FB))) >> (30 - FB);
         if (pos > ONE) pos = ONE;
         s   = half_wave_sine(r);
         spd = (s * HALF_PI_Q30 + (64'd1 << (59 - FB))) >> (60 - FB);
      end
      diff  = (tg >= st) ? 64'(tg - st) : 64'(st - tg);
      off   = (diff * pos + (ONE >> 1)) >> FB;
      angle = (tg >= st) ? st + off : st - off;
      lo    = (min_us <= max_us) ? 64'(min_us) : 64'(max_us);
      hi    = (min_us <= max_us) ? 64'(max_us) : 64'(min_us);
      span  = hi - lo;
      off   = (span * angle + 1440) / 2880;
      if (max_us >= min_us) begin
         pulse = min_us + off;
         if (pulse > hi) pulse = hi;
      end else begin
         pulse = (off >= 64'(min_us) - lo) ? lo : min_us - off;
      end
      if (done) spd_out = 0;
      else begin
         den     = t << FB;
         spd_out = (diff * spd * 1000 + (den >> 1)) / den;
         if (spd_out > 64'hFFFF) spd_out = 64'hFFFF;
      end
      w.pulse = pulse[PULSE_W-1:0];
      w.angle = angle[ANGLE_W-1:0];
      w.speed = spd_out[SPEED_W-1:0];
      w.done  = done;
      return w;
   endfunction

   assign pending = motion_q.size();

   always @(posedge clock) begin
      motion_word_type want;
      if (reset) begin
         mode     <= MODE_RESET;
         sweep_ms <= SWEEP_RESET;
         min_us   <= MIN_RESET;
         max_us   <= MAX_RESET;
         motion_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_PROFILE_MODE: mode     <= csr_data[0];
               CSR_SWEEP_TIME:   sweep_ms <= csr_data;
               CSR_MIN_PULSE:    min_us   <= csr_data[PULSE_W-1:0];
               CSR_MAX_PULSE:    max_us   <= csr_data[PULSE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            motion_q.push_back(predict_motion(req_elapsed_ms, req_start_angle,
                                              req_target_angle));
         if (rsp_valid && !rsp_stall) begin
            if (motion_q.size() == 0) begin
               $error("response word with no request outstanding");
               errors++;
            end else begin
               want = motion_q.pop_front();
               checked++;
               if (rsp_pulse_width_us !== want.pulse) begin
                  $error("pulse_width_us expected %0d got %0d", want.pulse,
                         rsp_pulse_width_us);
                  errors++;
               end
               if (rsp_angle_now !== want.angle) begin
                  $error("angle_now expected %0d got %0d", want.angle, rsp_angle_now);
                  errors++;
               end
               if (rsp_speed_now !== want.speed) begin
                  $error("speed_now expected %0d got %0d", want.speed, rsp_speed_now);
                  errors++;
               end
               if (rsp_sweep_done !== want.done) begin
                  $error("sweep_done expected %0d got %0d", want.done, rsp_sweep_done);
                  errors++;
               end
            end
         end
      end
   end
endmodule

### test/servo_motion_profile_generator_test.sv
module servo_motion_profile_generator_test import smpg_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int   NUM_PHASES  = 9;
   localparam int   RANDOM_EACH = 180;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_valid = 0;
   logic                   req_stall;
   logic [TIME_W-1:0]      req_elapsed_ms = '0;
   logic [ANGLE_W-1:0]     req_start_angle = '0;
   logic [ANGLE_W-1:0]     req_target_angle = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 0;
   logic [PULSE_W-1:0]     rsp_pulse_width_us;
   logic [ANGLE_W-1:0]     rsp_angle_now;
   logic [SPEED_W-1:0]     rsp_speed_now;
   logic                   rsp_sweep_done;
   logic                   csr_write = 0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PROFILE_MODE;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   int                     errors, pending, checked;
   int                     cycle = 0;
   logic [TIME_W-1:0]      sweep_now;

   // phase settings: mode, sweep time, min, max
   logic               ph_mode  [NUM_PHASES] =
      '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
   logic [TIME_W-1:0]  ph_sweep [NUM_PHASES] =
      '{16'd2000, 16'd2000, 16'd1, 16'd65535, 16'd0, 16'd300, 16'd65535, 16'd7,
        16'd1200};
   logic [PULSE_W-1:0] ph_min   [NUM_PHASES] =
      '{12'd500, 12'd500, 12'd0, 12'd4095, 12'd1000, 12'd2500, 12'd4095, 12'd0, 12'd0};
   logic [PULSE_W-1:0] ph_max   [NUM_PHASES] =
      '{12'd2500, 12'd2500, 12'd4095, 12'd0, 12'd2000, 12'd500, 12'd4095, 12'd0,
        12'd4095};

   servo_motion_profile_generator dut (.*);

   servo_motion_profile_checker checker_i (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) cycle <= cycle + 1;

   // no idling on either side while this holds
   function automatic logic calm();
      return cycle >= 1000 && cycle < 1800;
   endfunction

   // receiver: random stalls, one long hold-off to back the pipe up
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (cycle == 3000) hold = 400;
         if (hold > 0) begin
            rsp_stall = 1;
            hold--;
         end else if (calm()) rsp_stall = 0;
         else rsp_stall = ($urandom_range(99) < 34);
      end
   end

   task automatic send_word(input logic [TIME_W-1:0] el, input logic [ANGLE_W-1:0] st,
                            input logic [ANGLE_W-1:0] tg);
      @(negedge clock);
      while (!calm() && $urandom_range(99) < 34) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid        = 1;
      req_elapsed_ms   = el;
      req_start_angle  = st;
      req_target_angle = tg;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      req_valid = 0;
      csr_write = 1;
      csr_index = idx;
      csr_data  = val;
      @(negedge clock);
      csr_write = 0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [ANGLE_W-1:0] pick_angle();
      if ($urandom_range(99) < 85) return ANGLE_W'($urandom_range(2880));
      return ANGLE_W'($urandom_range(4095));
   endfunction

   initial begin
      logic [31:0] t, top;
      logic [TIME_W-1:0] edges [10];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            drain();
            write_reg(CSR_PROFILE_MODE,
                      CSR_DATA_W'(ph_mode[ph] ? PROFILE_SCURVE : PROFILE_TRAPEZOID));
            write_reg(CSR_SWEEP_TIME, ph_sweep[ph]);
            write_reg(CSR_MIN_PULSE, CSR_DATA_W'(ph_min[ph]));
            write_reg(CSR_MAX_PULSE, CSR_DATA_W'(ph_max[ph]));
         end
         sweep_now = ph_sweep[ph];
         t = (sweep_now == '0) ? 32'd1 : 32'(sweep_now);
         if (ph < 2) begin
            // start, thirds boundaries, end and past the end
            edges = '{16'd0, 16'd1, TIME_W'(t / 3), TIME_W'(t / 3 + 1),
                      TIME_W'(2 * t / 3), TIME_W'(2 * t / 3 + 1), TIME_W'(t - 1),
                      TIME_W'(t), TIME_W'(t + 1), 16'd65535};
            foreach (edges[i]) send_word(edges[i], 12'd0, 12'd2880);
            send_word(TIME_W'(t / 2), 12'd2880, 12'd0);
            send_word(TIME_W'(t / 2), 12'd4095, 12'd0);
            send_word(TIME_W'(t / 4), 12'd0, 12'd4095);
            send_word(TIME_W'(t / 2), 12'd1440, 12'd1440);
            send_word(TIME_W'(t / 2), 12'd4095, 12'd4095);
         end else begin
            send_word(16'd0, 12'd0, 12'd2880);
            send_word(TIME_W'(t), 12'd4095, 12'd0);
         end
         top = t + t / 8;
         if (top > 32'd65535) top = 32'd65535;
         for (int n = 0; n < RANDOM_EACH; n++) begin
            if ($urandom_range(99) < 80) send_word(TIME_W'($urandom_range(top)),
                                                   pick_angle(), pick_angle());
            else send_word(TIME_W'($urandom_range(65535)), pick_angle(), pick_angle());
         end
      end
      drain();
      $display("Checked %0d response words across %0d register settings: both profiles,",
               checked, NUM_PHASES);
      $display("swapped and equal pulse limits, zero and maximum sweep time, stalls.");
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end
endmodule
